@@ rtl/swmf_pkg.sv @@
// Shared types, constants and the engine state encoding for the sliding-window maximum filter.
package swmf_pkg;

    localparam int WINDOW_MAX   = 64;
    localparam int SAMPLE_WIDTH = 32;

    // Deque slot index, entry position (modulo 2*WINDOW_MAX) and entry count widths
    localparam int SLOT_W = $clog2(WINDOW_MAX);
    localparam int POS_W  = $clog2(2 * WINDOW_MAX);
    localparam int CNT_W  = $clog2(WINDOW_MAX + 1);
    localparam int CFG_W  = 7;

    // Front queue between input channel and deque engine
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QFILL_W     = QPTR_W + 1;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] sample;
        logic                           last_in;
    } sample_beat_t;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] window_max;
        logic                           last_out;
    } result_beat_t;

    // Oldest queued beat as seen by the engine
    typedef struct packed {
        logic         valid;
        sample_beat_t beat;
    } queue_head_t;

    // One deque entry as stored in the engine memory
    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] value;
        logic [POS_W-1:0]               position;
    } entry_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXPIRE,
        ST_EXPIRE_CHK,
        ST_TAIL,
        ST_TAIL_CHK,
        ST_APPEND,
        ST_EMIT
    } engine_state_t;

endpackage

@@ rtl/swmf_front.sv @@
// Input side: accepts sample beats and holds them in a short queue for the deque engine.
module swmf_front
    import swmf_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         sample_valid,
    output logic         sample_stall,
    input  sample_beat_t sample_data,
    input  logic         pop,
    output queue_head_t  head
);

    sample_beat_t        slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_next;
    logic [QFILL_W-1:0]  fill_reg;
    logic [QFILL_W-1:0]  fill_next;
    logic                push;
    logic                pull;

    assign sample_stall = (fill_reg == QFILL_W'(QUEUE_DEPTH));
    assign push         = sample_valid && !sample_stall;
    assign pull         = pop && (fill_reg != '0);

    assign head.valid = (fill_reg != '0);
    assign head.beat  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pull ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        unique case ({push, pull})
            2'b10:   fill_next = fill_reg + 1'b1;
            2'b01:   fill_next = fill_reg - 1'b1;
            default: fill_next = fill_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= sample_data;
        end
    end

    // Queue never overflows or underflows
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= QFILL_W'(QUEUE_DEPTH))
        else $error("front queue fill out of range");

    a_fill_track: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pull) |=> (fill_reg == $past(fill_reg) + 1'b1))
        else $error("front queue fill did not advance on push");

    a_pull_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head.valid)
        else $error("engine popped an empty queue");

endmodule

@@ rtl/swmf_back.sv @@
// Deque engine: window register, deque memory, expire/drop/append sequencer and result register.
module swmf_back
    import swmf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               window_size_we,
    input  logic [CFG_W-1:0]   window_size_wdata,
    input  queue_head_t        head,
    output logic               pop,
    output logic               result_valid,
    input  logic               result_stall,
    output result_beat_t       result_data
);

    entry_t               mem [WINDOW_MAX];
    entry_t               rd_data_reg;
    logic                 rd_en;
    logic [SLOT_W-1:0]    rd_addr;
    logic                 wr_en;

    engine_state_t        state_reg, state_next;
    logic [CFG_W-1:0]     window_size_reg;
    logic [CNT_W-1:0]     k_eff;
    logic [CNT_W-1:0]     k_reg, k_next;
    logic [SLOT_W-1:0]    head_reg, head_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [POS_W-1:0]     pos_reg, pos_next;
    logic [CNT_W-1:0]     seen_reg, seen_next;
    logic                 emit_reg, emit_next;
    logic                 front_new_reg, front_new_next;
    logic                 out_valid_reg, out_valid_next;
    sample_beat_t         cur_reg, cur_next;
    result_beat_t         out_data_reg, out_data_next;

    logic [CNT_W-1:0]     tail_sum;
    logic [CNT_W-1:0]     last_sum;
    logic [POS_W-1:0]     age;

    assign result_valid = out_valid_reg;
    assign result_data  = out_data_reg;

    // Clamp the window length into 1..WINDOW_MAX
    always_comb
    begin
        if (window_size_reg == '0)
            k_eff = CNT_W'(1);
        else if (CNT_W'(window_size_reg) > CNT_W'(WINDOW_MAX))
            k_eff = CNT_W'(WINDOW_MAX);
        else
            k_eff = CNT_W'(window_size_reg);
    end

    assign tail_sum = CNT_W'(head_reg) + count_reg;
    assign last_sum = tail_sum - 1'b1;
    assign age      = pos_reg - rd_data_reg.position;

    always_comb
    begin
        state_next     = state_reg;
        k_next         = k_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        pos_next       = pos_reg;
        seen_next      = seen_reg;
        emit_next      = emit_reg;
        front_new_next = front_new_reg;
        cur_next       = cur_reg;
        out_valid_next = out_valid_reg && result_stall;
        out_data_next  = out_data_reg;
        pop            = 1'b0;
        rd_en          = 1'b0;
        rd_addr        = head_reg;
        wr_en          = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (head.valid)
                begin
                    pop        = 1'b1;
                    cur_next   = head.beat;
                    k_next     = k_eff;
                    state_next = ST_EXPIRE;
                end
            end
            ST_EXPIRE:
            begin
                if (count_reg == '0)
                    state_next = ST_TAIL;
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = head_reg;
                    state_next = ST_EXPIRE_CHK;
                end
            end
            ST_EXPIRE_CHK:
            begin
                if (CNT_W'(age) >= k_reg)
                begin
                    head_next  = head_reg + 1'b1;
                    count_next = count_reg - 1'b1;
                    state_next = ST_EXPIRE;
                end
                else
                    state_next = ST_TAIL;
            end
            ST_TAIL:
            begin
                if (count_reg == '0)
                    state_next = ST_APPEND;
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = last_sum[SLOT_W-1:0];
                    state_next = ST_TAIL_CHK;
                end
            end
            ST_TAIL_CHK:
            begin
                if ($signed(rd_data_reg.value) <= $signed(cur_reg.sample))
                begin
                    count_next = count_reg - 1'b1;
                    state_next = ST_TAIL;
                end
                else
                    state_next = ST_APPEND;
            end
            ST_APPEND:
            begin
                if (count_reg < CNT_W'(WINDOW_MAX))
                begin
                    wr_en      = 1'b1;
                    count_next = count_reg + 1'b1;
                end
                front_new_next = (count_reg == '0);
                rd_en          = 1'b1;
                rd_addr        = head_reg;
                pos_next       = pos_reg + 1'b1;
                seen_next      = (seen_reg < k_reg) ? seen_reg + 1'b1 : k_reg;
                emit_next      = (seen_next == k_reg);
                state_next     = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!emit_reg || !out_valid_reg || !result_stall)
                begin
                    if (emit_reg)
                    begin
                        out_valid_next           = 1'b1;
                        out_data_next.window_max = front_new_reg ? cur_reg.sample
                                                                 : rd_data_reg.value;
                        out_data_next.last_out   = cur_reg.last_in;
                    end
                    if (cur_reg.last_in)
                    begin
                        head_next  = '0;
                        count_next = '0;
                        pos_next   = '0;
                        seen_next  = '0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            window_size_reg <= CFG_W'(1);
            k_reg           <= CNT_W'(1);
            head_reg        <= '0;
            count_reg       <= '0;
            pos_reg         <= '0;
            seen_reg        <= '0;
            emit_reg        <= 1'b0;
            front_new_reg   <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            if (window_size_we)
                window_size_reg <= window_size_wdata;
            k_reg         <= k_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            pos_reg       <= pos_next;
            seen_reg      <= seen_next;
            emit_reg      <= emit_next;
            front_new_reg <= front_new_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        out_data_reg <= out_data_next;
    end

    // Deque memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[tail_sum[SLOT_W-1:0]] <= '{value: cur_reg.sample, position: pos_reg};
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(WINDOW_MAX))
        else $error("deque count above capacity");

    a_seen_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> (seen_reg <= k_reg))
        else $error("samples seen above window length");

    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (state_reg == ST_IDLE))
        else $error("queue popped while engine busy");

    a_append_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_APPEND) |=> (state_reg == ST_EMIT))
        else $error("append not followed by emit");

endmodule

@@ rtl/sliding_window_max_filter.sv @@
// Top level of the sliding-window maximum filter: front queue plus deque engine.
//
//  Channel   Signals                                     Direction  Beat
//  sample    sample_valid / sample_stall / sample_data   in         sample_beat_t
//  result    result_valid / result_stall / result_data   out        result_beat_t
//  config    window_size_we / window_size_wdata          in         7-bit window length
//
//  Per sample the engine pops a beat, expires old entries from the front, drops entries
//  not above the sample from the back, appends the sample and emits the front value; each
//  entry checked at either end is read through the deque memory's one registered read
//  port. Every entry is dropped at most once.
//  Reset clears the queue, the deque pointers and counters, and sets window_size to 1;
//  the deque memory needs no clearing since only live entries are ever used.
//  The front queue keeps accepting beats while the engine works or while a result is
//  stalled in the output register; sample_stall rises only when the queue is full.
module sliding_window_max_filter
    import swmf_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             window_size_we,
    input  logic [CFG_W-1:0] window_size_wdata,
    input  logic             sample_valid,
    output logic             sample_stall,
    input  sample_beat_t     sample_data,
    output logic             result_valid,
    input  logic             result_stall,
    output result_beat_t     result_data
);

    // Oldest queued beat and the engine's request to take it
    queue_head_t queue_head;
    logic        queue_pop;

    // Front: accept sample beats and hold them until the engine is free
    swmf_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample_data  (sample_data),
        .pop          (queue_pop),
        .head         (queue_head)
    );

    // Back: expire old entries, drop those not above the new sample, append, and emit the front value
    swmf_back u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .window_size_we    (window_size_we),
        .window_size_wdata (window_size_wdata),
        .head              (queue_head),
        .pop               (queue_pop),
        .result_valid      (result_valid),
        .result_stall      (result_stall),
        .result_data       (result_data)
    );

endmodule

@@ dv/window_max_checker.sv @@
// Checker for the sliding-window maximum filter: tracks the window deque and compares result beats.
module window_max_checker
    import swmf_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             window_size_we,
    input  logic [CFG_W-1:0] window_size_wdata,
    input  logic             sample_valid,
    input  logic             sample_stall,
    input  sample_beat_t     sample_data,
    input  logic             result_valid,
    input  logic             result_stall,
    input  result_beat_t     result_data,
    output int               mismatch_count,
    output int               pending_results,
    output int               results_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int REPORT_LIMIT = 10;

    logic [CFG_W-1:0] window_len;
    logic [POS_W-1:0] next_position;
    logic [CFG_W-1:0] seen_count;
    entry_t           live_entries[$];
    result_beat_t     expected_maxima[$];
    int               fail_total;

    function automatic void clear_sequence_state();
        live_entries.delete();
        next_position = '0;
        seen_count    = '0;
    endfunction

    // Advance the deque by one sample; return 1 when a full window yields a maximum.
    function automatic bit take_sample(input sample_beat_t beat, output result_beat_t res);
        logic [CFG_W-1:0] span;
        logic [POS_W-1:0] age;
        bit               produced;
        entry_t           fresh;
        span = window_len;
        if (span == 0)
            span = CFG_W'(1);
        if (span > WINDOW_MAX)
            span = CFG_W'(WINDOW_MAX);
        // expire from the front, position arithmetic wraps at the counter width
        while (live_entries.size() > 0)
        begin
            age = next_position - live_entries[0].position;
            if (age < span)
                break;
            live_entries.delete(0);
        end
        // drop from the back anything not above the new sample (newer wins ties)
        while (live_entries.size() > 0 && live_entries[$].value <= beat.sample)
            live_entries.delete(live_entries.size() - 1);
        if (live_entries.size() < WINDOW_MAX)
        begin
            fresh.value    = beat.sample;
            fresh.position = next_position;
            live_entries.insert(live_entries.size(), fresh);
        end
        next_position = next_position + 1'b1;
        if (seen_count < span)
            seen_count = seen_count + 1'b1;
        if (seen_count > span)
            seen_count = span;
        produced       = (seen_count >= span);
        res.window_max = live_entries[0].value;
        res.last_out   = beat.last_in;
        if (beat.last_in)
            clear_sequence_state();
        return produced;
    endfunction

    function automatic void report_failure(input string msg);
        fail_total++;
        if (fail_total <= REPORT_LIMIT)
            $display("[%0t] MISMATCH: %s", $realtime, msg);
    endfunction

    always @(posedge clk)
    begin
        result_beat_t want;
        result_beat_t predicted;
        if (!rst_n)
        begin
            window_len = CFG_W'(1);
            clear_sequence_state();
            expected_maxima.delete();
            fail_total      = 0;
            results_checked <= 0;
        end
        else
        begin
            if (window_size_we)
                window_len = window_size_wdata;
            if (result_valid && !result_stall)
            begin
                if (expected_maxima.size() == 0)
                    report_failure($sformatf("result beat with none expected: max %0d last %0b",
                                             result_data.window_max, result_data.last_out));
                else
                begin
                    want = expected_maxima[0];
                    expected_maxima.delete(0);
                    results_checked <= results_checked + 1;
                    if (result_data.window_max !== want.window_max)
                        report_failure($sformatf("window_max expected %0d (%h) got %0d (%h)",
                                                 want.window_max, want.window_max,
                                                 result_data.window_max,
                                                 result_data.window_max));
                    if (result_data.last_out !== want.last_out)
                        report_failure($sformatf("last_out expected %0b got %0b",
                                                 want.last_out, result_data.last_out));
                end
            end
            if (sample_valid && !sample_stall && take_sample(sample_data, predicted))
                expected_maxima.insert(expected_maxima.size(), predicted);
        end
        mismatch_count  <= fail_total;
        pending_results <= expected_maxima.size();
    end

endmodule

@@ dv/sliding_window_max_filter_test.sv @@
// Testbench top for the sliding-window maximum filter: stimulus, flow control, watchdog, verdict.
module sliding_window_max_filter_test;
    timeunit 1ns;
    timeprecision 1ps;

    import swmf_pkg::*;

    // Settle time before a register write: one beat can drop a full deque from
    // the back, and the front queue may still hold a few beats that produce no
    // result. Allow for all of them with margin.
    localparam int SETTLE_CYCLES   = 800;
    localparam int HOLD_OFF_CYCLES = 600;
    localparam int STALL_LIMIT     = 20000;
    localparam int RANDOM_BEATS    = 1600;
    localparam int PHASE_BEATS     = 100;
    localparam int PRESSURE_BEATS  = 60;

    localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MIN = 32'sh8000_0000;

    // Window register values walked through first in the random part; the rest
    // are drawn at random. Includes the out-of-range codes 0, 65 and 127.
    localparam int PLAN_LEN = 11;
    localparam logic [CFG_W-1:0] WINDOW_PLAN [PLAN_LEN] =
        '{7'd2, 7'd64, 7'd1, 7'd65, 7'd5, 7'd127, 7'd0, 7'd16, 7'd3, 7'd40, 7'd8};

    typedef enum int {
        FLOW_FREE,
        FLOW_SENDER_IDLE,
        FLOW_RECEIVER_STALL,
        FLOW_BOTH
    } flow_mode_t;

    typedef enum int {
        VAL_RANDOM,
        VAL_TIGHT,
        VAL_FALLING,
        VAL_RISING,
        VAL_EXTREME
    } value_style_t;

    logic             clk               = 1'b0;
    logic             rst_n             = 1'b0;
    logic             window_size_we    = 1'b0;
    logic [CFG_W-1:0] window_size_wdata = '0;
    logic             sample_valid      = 1'b0;
    logic             sample_stall;
    sample_beat_t     sample_data       = '0;
    logic             result_valid;
    logic             result_stall      = 1'b0;
    result_beat_t     result_data;

    int mismatch_count;
    int pending_results;
    int results_checked;

    // Flow-control knobs, changed only between phases
    int sender_idle_pct   = 0;
    int receiver_stall_pct = 0;
    bit hold_off_request  = 1'b0;

    // Run statistics for the summary
    int beats_sent      = 0;
    int sequences_ended = 0;
    int window_writes   = 0;

    sliding_window_max_filter u_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .window_size_we    (window_size_we),
        .window_size_wdata (window_size_wdata),
        .sample_valid      (sample_valid),
        .sample_stall      (sample_stall),
        .sample_data       (sample_data),
        .result_valid      (result_valid),
        .result_stall      (result_stall),
        .result_data       (result_data)
    );

    window_max_checker u_checker (
        .clk               (clk),
        .rst_n             (rst_n),
        .window_size_we    (window_size_we),
        .window_size_wdata (window_size_wdata),
        .sample_valid      (sample_valid),
        .sample_stall      (sample_stall),
        .sample_data       (sample_data),
        .result_valid      (result_valid),
        .result_stall      (result_stall),
        .result_data       (result_data),
        .mismatch_count    (mismatch_count),
        .pending_results   (pending_results),
        .results_checked   (results_checked)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Result side: stall at the phase's rate. On request, hold off for a long
    // stretch so the engine backs up into the front queue and the input stalls.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_off_request)
            begin
                hold_off_request = 1'b0;
                result_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end
            result_stall <= ($urandom_range(99) < receiver_stall_pct);
        end
    end

    // Watchdog: count cycles in which no beat moves on either channel and no
    // register write happens; give up once the count reaches the limit.
    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((sample_valid && !sample_stall) || (result_valid && !result_stall) ||
                window_size_we)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("Watchdog: no beat moved for %0d cycles, %0d results outstanding",
                         quiet_cycles, pending_results);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    function automatic void set_flow(input flow_mode_t mode);
        case (mode)
            FLOW_FREE:
            begin
                sender_idle_pct    = 0;
                receiver_stall_pct = 0;
            end
            FLOW_SENDER_IDLE:
            begin
                sender_idle_pct    = 79;
                receiver_stall_pct = 0;
            end
            FLOW_RECEIVER_STALL:
            begin
                sender_idle_pct    = 0;
                receiver_stall_pct = 79;
            end
            default:
            begin
                sender_idle_pct    = 24;
                receiver_stall_pct = 24;
            end
        endcase
    endfunction

    // Offer one sample beat after a random gap; hold it until accepted.
    // Called just after a rising edge; returns just after the accepting edge
    // with valid still high, so back-to-back beats need no extra assignment.
    task automatic send_beat(input logic signed [SAMPLE_WIDTH-1:0] value, input logic last);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            sample_valid <= 1'b0;
            @(posedge clk);
        end
        sample_valid <= 1'b1;
        sample_data  <= '{sample: value, last_in: last};
        @(posedge clk);
        while (sample_stall)
            @(posedge clk);
        beats_sent++;
        if (last)
            sequences_ended++;
    endtask

    // Send one sequence of len beats in the given value style; mark the final
    // beat last only when close is set, else leave the sequence open.
    task automatic send_sequence(input int len, input value_style_t style, input bit close);
        logic signed [SAMPLE_WIDTH-1:0] start;
        logic signed [SAMPLE_WIDTH-1:0] value;
        int                             step;
        start = $urandom;
        step  = $urandom_range(0, 3);
        for (int i = 0; i < len; i++)
        begin
            case (style)
                VAL_TIGHT:   value = $signed($urandom_range(0, 6)) - 3;
                VAL_FALLING: value = start - i * step;
                VAL_RISING:  value = start + i * step;
                VAL_EXTREME:
                    case ($urandom_range(4))
                        0:       value = SAMPLE_MAX;
                        1:       value = SAMPLE_MIN;
                        2:       value = '0;
                        3:       value = -1;
                        default: value = $urandom;
                    endcase
                default:     value = $urandom;
            endcase
            send_beat(value, close && (i == len - 1));
        end
    endtask

    // Drop valid, wait until every expected result has arrived, then let the
    // engine finish any beat that produces no result.
    task automatic wait_idle();
        sample_valid <= 1'b0;
        @(posedge clk);
        while (pending_results != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_window(input logic [CFG_W-1:0] len_code);
        window_size_we    <= 1'b1;
        window_size_wdata <= len_code;
        @(posedge clk);
        window_size_we    <= 1'b0;
        window_writes++;
    endtask

    // One random phase: set the window, pick the flow mode, then stream mostly
    // full-length sequences with some short ones; the final sequence may stay
    // open so the next window setting lands mid-sequence.
    task automatic run_random_phase(input logic [CFG_W-1:0] len_code, input flow_mode_t mode);
        int           span;
        int           len;
        int           phase_beats;
        value_style_t style;
        bit           close;
        wait_idle();
        write_window(len_code);
        set_flow(mode);
        span        = (len_code == 0) ? 1 : (len_code > WINDOW_MAX) ? WINDOW_MAX : len_code;
        phase_beats = 0;
        while (phase_beats < PHASE_BEATS)
        begin
            if ($urandom_range(9) < 8)
                len = span + $urandom_range(0, 2 * span + 8);
            else
                len = $urandom_range(1, span);
            style = value_style_t'($urandom_range(4));
            close = !((phase_beats + len >= PHASE_BEATS) && ($urandom_range(1) == 1));
            send_sequence(len, style, close);
            phase_beats += len;
        end
    endtask

    initial
    begin
        int               random_start;
        int               phase;
        logic [CFG_W-1:0] len_code;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        set_flow(FLOW_FREE);

        // Window left at its reset length of one: every beat is its own maximum.
        send_beat(SAMPLE_MAX, 1'b0);
        send_beat(SAMPLE_MIN, 1'b0);
        send_beat('0, 1'b0);
        send_beat(-1, 1'b1);

        // Window of three: equal values, a falling run, then a new peak.
        wait_idle();
        write_window(7'd3);
        send_beat(10, 1'b0);
        send_beat(10, 1'b0);
        send_beat(10, 1'b0);
        send_beat(9, 1'b0);
        send_beat(8, 1'b0);
        send_beat(7, 1'b0);
        send_beat(20, 1'b1);

        // Sequence ending before a full window: no result, state still clears.
        send_beat(1, 1'b0);
        send_beat(2, 1'b1);

        // Zero length acts as one.
        wait_idle();
        write_window(7'd0);
        send_beat(-5, 1'b0);
        send_beat(5, 1'b0);
        send_beat(-5, 1'b1);

        // Above the maximum acts as the maximum: three beats stay short of it.
        wait_idle();
        write_window(7'd127);
        send_beat(SAMPLE_MIN, 1'b0);
        send_beat(SAMPLE_MAX, 1'b0);
        send_beat(0, 1'b1);

        // Shrink the window mid-sequence: old front entries expire at once.
        wait_idle();
        write_window(7'd4);
        send_beat(5, 1'b0);
        send_beat(4, 1'b0);
        send_beat(3, 1'b0);
        send_beat(2, 1'b0);
        wait_idle();
        write_window(7'd2);
        send_beat(1, 1'b1);

        random_start = beats_sent;

        // Back pressure: hold the result side off while beats keep coming, so
        // the output register and the front queue fill and the input stalls.
        wait_idle();
        write_window(7'd1);
        set_flow(FLOW_FREE);
        hold_off_request = 1'b1;
        send_sequence(PRESSURE_BEATS, VAL_RANDOM, 1'b1);

        phase = 0;
        while (beats_sent - random_start < RANDOM_BEATS)
        begin
            if (phase < PLAN_LEN)
                len_code = WINDOW_PLAN[phase];
            else if ($urandom_range(9) < 7)
                len_code = CFG_W'($urandom_range(1, 16));
            else
                len_code = CFG_W'($urandom_range(0, 127));
            run_random_phase(len_code, flow_mode_t'(phase % 4));
            phase++;
        end

        // Drain: wait for every expected maximum, then for the engine to settle
        // so that any stray result beat shows up in the checker.
        wait_idle();

        $display("Run covered %0d sample beats, %0d closed sequences, %0d window writes;",
                 beats_sent, sequences_ended, window_writes);
        $display("%0d window maxima checked against prediction, %0d mismatches.",
                 results_checked, mismatch_count);
        if (mismatch_count == 0 && pending_results == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
